@@ rtl/core/ppu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types, constants and helpers of the particle pool update core
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;

    // divider: |life| (up to 2^31) shifted by 16 over a 31 bit lifetime
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 31;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [18:0] TWO_PI_Q16    = 19'd411775;
    localparam logic [25:0] HUNDREDTH_Q32 = 26'd42949673;

    // request kinds carried on tuser
    localparam logic REQ_EMIT = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_VEL_VAR_X = 2'd0;
    localparam logic [1:0] CFG_VEL_VAR_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_VAR  = 2'd2;

    // one pool entry as held in the memory
    typedef struct packed {
        logic signed [31:0] final_size;
        logic signed [31:0] start_size;
        logic signed [31:0] life_total;
        logic signed [31:0] life_left;
        logic        [31:0] rotation;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/particle_pool_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_update_core
// ring pool of particles in Q16.16: emit into a ring slot, tick and report
// ----------------------------------------------------------------------------
// usage
// - s_axis carries requests: tuser selects emit or tick, tdata the payload
// - an emit writes the slot at the ring index
// - a tick walks all slots in ascending order; an inactive slot is only scanned,
//   an expired one is dropped after its load, and a live one runs the position,
//   divide (waiting on the life fraction divider), size and output states
// - m_axis gives one transaction per particle still alive after the tick,
//   tlast on the final one; a tick with no live particle gives nothing
// - the newest result is held back one slot so tlast can be decided
// - a stalled m_axis only holds up the walk when both output and holding
//   registers are full; the next request is taken while the last result waits
// - cfg writes the variation spans; it is always ready, indexes past the list
//   are ignored; write only while the core is idle
// - reset clears all active flags and the config, and sets the ring index to
//   the top slot; entry memory is not cleared (a slot is read only when active)
// ----------------------------------------------------------------------------
module particle_pool_update_core
    import ppu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // cfg write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, duration(31), size_begin, size_end,
    // rand_angle, rand_vel_x, rand_vel_y, rand_size(16 each), 1 pad bit
    input  logic [287:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // req_type
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pos_x, out_pos_y, out_rotation, out_size, life_fraction
    output logic [159:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EMIT  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_LOAD  = 9'b000001000,
        S_POS   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_SIZE  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_FLUSH = 9'b100000000
    } state_t;

    state_t state_reg;

    // config
    logic signed [31:0] vel_var_x_reg, vel_var_y_reg, size_var_reg;

    // latched request
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic        [30:0] duration_reg;
    logic signed [31:0] size_begin_reg, size_end_reg;
    logic        [15:0] rand_angle_reg, rand_vel_x_reg, rand_vel_y_reg, rand_size_reg;
    logic        [31:0] drot_reg;

    logic [POOL_SIZE-1:0] active_reg;
    logic [SLOT_W-1:0]    emit_slot_reg;
    logic [SLOT_W-1:0]    idx_reg;

    // per slot work registers
    entry_t             ent_reg;
    logic signed [63:0] prod_x_reg, prod_y_reg;
    logic signed [31:0] frac_reg;
    logic signed [64:0] size_prod_reg;

    // holding and output registers
    logic [159:0] pend_reg;
    logic         pend_valid_reg;
    logic [159:0] out_data_reg;
    logic         out_valid_reg;
    logic         out_last_reg;

    logic   in_fire;
    logic   last_slot;
    logic   out_free;
    logic   out_load;
    entry_t rdata;
    entry_t emit_ent;
    entry_t load_ent;
    entry_t wb_ent;
    entry_t wdata;
    logic   mem_we;
    logic [SLOT_W-1:0] waddr;

    logic signed [31:0] ts_s;
    logic signed [16:0] rvx_s, rvy_s, rs_s;
    logic signed [48:0] var_vx, var_vy, var_sz;
    logic        [34:0] rot_prod;
    logic        [57:0] drot_prod;
    logic signed [31:0] new_left;

    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 left_neg;
    logic [31:0]          left_mag;
    logic signed [31:0]   frac_calc;
    logic signed [32:0]   size_diff;
    logic signed [31:0]   size_calc;
    logic [159:0]         result;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign last_slot = (idx_reg == SLOT_W'(POOL_SIZE - 1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    // holding register moves into the output register this cycle
    assign out_load  = pend_valid_reg && out_free &&
                       ((state_reg == S_OUT) || (state_reg == S_FLUSH));

    // emit arithmetic
    assign ts_s  = $signed({1'b0, duration_reg});
    assign rvx_s = $signed({1'b0, rand_vel_x_reg}) - 17'sd32768;
    assign rvy_s = $signed({1'b0, rand_vel_y_reg}) - 17'sd32768;
    assign rs_s  = $signed({1'b0, rand_size_reg}) - 17'sd32768;
    assign var_vx = vel_var_x_reg * rvx_s;
    assign var_vy = vel_var_y_reg * rvy_s;
    assign var_sz = size_var_reg * rs_s;
    assign rot_prod = 35'(rand_angle_reg) * 35'(TWO_PI_Q16) + 35'd32768;

    always_comb
    begin
        emit_ent.pos_x      = pos_x_reg;
        emit_ent.pos_y      = pos_y_reg;
        emit_ent.vel_x      = sat32(64'(vel_x_reg) + 64'(var_vx >>> 16));
        emit_ent.vel_y      = sat32(64'(vel_y_reg) + 64'(var_vy >>> 16));
        emit_ent.rotation   = 32'(rot_prod[34:16]);
        emit_ent.life_left  = ts_s;
        emit_ent.life_total = ts_s;
        emit_ent.start_size = sat32(64'(size_begin_reg) + 64'(var_sz >>> 16));
        emit_ent.final_size = size_end_reg;
    end

    // rotation step per tick, 0.01 in Q0.32 with rounding
    assign drot_prod = 58'(s_axis_tdata[158:128]) * 58'(HUNDREDTH_Q32) + 58'h80000000;

    // life after the step, fits in 32 bits
    assign new_left = rdata.life_left - ts_s;

    // entry as loaded: life and rotation stepped
    always_comb
    begin
        load_ent           = rdata;
        load_ent.life_left = new_left;
        load_ent.rotation  = rdata.rotation + drot_reg;
    end

    // position write-back
    always_comb
    begin
        wb_ent       = ent_reg;
        wb_ent.pos_x = sat32(64'(ent_reg.pos_x) + (prod_x_reg >>> 16));
        wb_ent.pos_y = sat32(64'(ent_reg.pos_y) + (prod_y_reg >>> 16));
    end

    assign mem_we = (state_reg == S_EMIT) || (state_reg == S_POS);
    assign waddr  = (state_reg == S_EMIT) ? emit_slot_reg : idx_reg;
    assign wdata  = (state_reg == S_EMIT) ? emit_ent : wb_ent;

    // no overlap: each slot is read once per tick and written back before
    // the walk moves on, emits never run during a tick
    ppu_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // life fraction: |left| * 65536 / total, sign restored afterwards
    assign left_neg  = wb_ent.life_left[31];
    assign left_mag  = left_neg ? (32'd0 - wb_ent.life_left) : wb_ent.life_left;
    assign div_start = (state_reg == S_POS);

    ppu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({left_mag, 16'd0}),
        .den   (ent_reg.life_total[DIV_DEN_W-1:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        if (ent_reg.life_total == 32'sd0)
            frac_calc = 32'sd0;
        else if (ent_reg.life_left[31])
        begin
            if (div_quo > DIV_NUM_W'(32'h80000000))
                frac_calc = 32'sh80000000;
            else
                frac_calc = $signed(32'd0 - div_quo[31:0]);
        end
        else
        begin
            if (div_quo > DIV_NUM_W'(32'h7fffffff))
                frac_calc = 32'sh7fffffff;
            else
                frac_calc = $signed(div_quo[31:0]);
        end
    end

    assign size_diff = 33'(ent_reg.start_size) - 33'(ent_reg.final_size);
    assign size_calc = sat32(64'(ent_reg.final_size) + 64'(size_prod_reg >>> 16));
    assign result    = {frac_reg, size_calc, ent_reg.rotation, ent_reg.pos_y, ent_reg.pos_x};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vel_var_x_reg  <= '0;
            vel_var_y_reg  <= '0;
            size_var_reg   <= '0;
            active_reg     <= '0;
            emit_slot_reg  <= SLOT_W'(POOL_SIZE - 1);
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_VEL_VAR_X: vel_var_x_reg <= cfg_data;
                    CFG_VEL_VAR_Y: vel_var_y_reg <= cfg_data;
                    CFG_SIZE_VAR:  size_var_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg <= '0;
                        state_reg <= (s_axis_tuser == REQ_EMIT) ? S_EMIT : S_SCAN;
                    end
                end
                S_EMIT:
                begin
                    active_reg[emit_slot_reg] <= 1'b1;
                    if (emit_slot_reg == '0)
                        emit_slot_reg <= SLOT_W'(POOL_SIZE - 1);
                    else
                        emit_slot_reg <= emit_slot_reg - 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (active_reg[idx_reg])
                        state_reg <= S_LOAD;
                    else if (last_slot)
                        state_reg <= S_FLUSH;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_LOAD:
                begin
                    if (rdata.life_left <= 32'sd0)
                    begin
                        // expired: drop without report
                        active_reg[idx_reg] <= 1'b0;
                        if (last_slot)
                            state_reg <= S_FLUSH;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                        state_reg <= S_POS;
                end
                S_POS:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_SIZE;
                end
                S_SIZE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        if (last_slot)
                            state_reg <= S_FLUSH;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_x_reg      <= s_axis_tdata[31:0];
            pos_y_reg      <= s_axis_tdata[63:32];
            vel_x_reg      <= s_axis_tdata[95:64];
            vel_y_reg      <= s_axis_tdata[127:96];
            duration_reg   <= s_axis_tdata[158:128];
            size_begin_reg <= s_axis_tdata[190:159];
            size_end_reg   <= s_axis_tdata[222:191];
            rand_angle_reg <= s_axis_tdata[238:223];
            rand_vel_x_reg <= s_axis_tdata[254:239];
            rand_vel_y_reg <= s_axis_tdata[270:255];
            rand_size_reg  <= s_axis_tdata[286:271];
            drot_reg       <= 32'(drot_prod[57:32]);
        end

        if (state_reg == S_LOAD)
        begin
            ent_reg    <= load_ent;
            prod_x_reg <= rdata.vel_x * 64'(ts_s);
            prod_y_reg <= rdata.vel_y * 64'(ts_s);
        end

        if (state_reg == S_POS)
        begin
            ent_reg <= wb_ent;
        end

        if (state_reg == S_DIV && div_done)
        begin
            frac_reg <= frac_calc;
        end

        if (state_reg == S_SIZE)
        begin
            size_prod_reg <= size_diff * 65'(frac_reg);
        end

        if (state_reg == S_OUT && (!pend_valid_reg || out_free))
        begin
            if (pend_valid_reg)
                out_data_reg <= pend_reg;
            pend_reg <= result;
        end

        if (state_reg == S_FLUSH && pend_valid_reg && out_free)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/core/ppu_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_mem
// pool entry memory, one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ppu_mem
    import ppu_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [SLOT_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [POOL_SIZE];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ppu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppu_div
    import ppu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W+1:0] trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]} - {2'b00, den_reg};
        if (!trial[DIV_DEN_W+1])
        begin
            rem_next = trial[DIV_DEN_W:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for particle_pool_update_core
// ----------------------------------------------------------------------------
// emit and tick requests go in over s_axis in random bursts while m_axis stalls
// on its own pattern; a pool predictor in the bench works out every particle
// report, and each m_axis transaction is checked field by field against the
// oldest pending report; the variation spans are rewritten between phases
// ----------------------------------------------------------------------------
module tb
    import ppu_pkg::*;
();

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // past the register list
    localparam int   LIMIT_CYCLES    = 8000000;
    localparam int   DRAIN_CYCLES    = 300;      // a full walk of idle slots and margin
    localparam int   ONE             = 65536;    // 1.0 in Q16.16

    typedef struct {
        logic               kind;
        logic signed [31:0] px, py, vx, vy;
        logic        [30:0] dur;
        logic signed [31:0] sb, se;
        logic        [15:0] ra, rvx, rvy, rs;
    } req_t;

    typedef struct {
        logic [31:0] px, py, rot, size, frac;
        logic        last;
    } report_t;

    // directed row: typed_n < 0 leaves the check to the predictor
    typedef struct {
        req_t    r;
        int      typed_n;
        report_t typed;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tlast;

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    // predictor copy of the pool
    logic signed [31:0] span_vx, span_vy, span_size;
    logic               alive [POOL_SIZE];
    logic signed [31:0] p_x [POOL_SIZE], p_y [POOL_SIZE];
    logic signed [31:0] v_x [POOL_SIZE], v_y [POOL_SIZE];
    logic        [31:0] angle [POOL_SIZE];
    logic signed [31:0] life [POOL_SIZE], lifetime [POOL_SIZE];
    logic signed [31:0] size0 [POOL_SIZE], size1 [POOL_SIZE];
    int                 ring_slot;

    report_t pending_reports[$];

    particle_pool_update_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // arithmetic shift rounds toward minus infinity
    function automatic longint floor16(input longint x);
        return x >>> 16;
    endfunction

    // apply one request to the pool copy, queue the reports it causes
    function automatic int advance_pool(input req_t r);
        longint  ts;
        logic [63:0] drot;
        longint  fr;
        logic signed [31:0] frac;
        report_t rep;
        int      n;
        n = 0;
        if (r.kind == REQ_EMIT)
        begin
            alive[ring_slot]    = 1'b1;
            p_x[ring_slot]      = r.px;
            p_y[ring_slot]      = r.py;
            angle[ring_slot]    = 32'((64'(r.ra) * 64'd411775 + 64'd32768) >> 16);
            v_x[ring_slot]      = clamp32(longint'(r.vx) +
                floor16(longint'(span_vx) * (longint'(r.rvx) - 32768)));
            v_y[ring_slot]      = clamp32(longint'(r.vy) +
                floor16(longint'(span_vy) * (longint'(r.rvy) - 32768)));
            lifetime[ring_slot] = {1'b0, r.dur};
            life[ring_slot]     = {1'b0, r.dur};
            size0[ring_slot]    = clamp32(longint'(r.sb) +
                floor16(longint'(span_size) * (longint'(r.rs) - 32768)));
            size1[ring_slot]    = r.se;
            ring_slot = (ring_slot == 0) ? POOL_SIZE - 1 : ring_slot - 1;
            return 0;
        end
        ts   = longint'(r.dur);
        drot = (64'(r.dur) * 64'd42949673 + 64'h8000_0000) >> 32;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (!alive[i])
                continue;
            if (life[i] <= 0)
            begin
                alive[i] = 1'b0;
                continue;
            end
            life[i]  = clamp32(longint'(life[i]) - ts);
            p_x[i]   = clamp32(longint'(p_x[i]) + floor16(longint'(v_x[i]) * ts));
            p_y[i]   = clamp32(longint'(p_y[i]) + floor16(longint'(v_y[i]) * ts));
            angle[i] = angle[i] + drot[31:0];
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (!alive[i])
                continue;
            if (lifetime[i] == 0)
                frac = 0;
            else
            begin
                fr   = (longint'(life[i]) * 65536) / longint'(lifetime[i]);
                frac = clamp32(fr);
            end
            rep.px   = p_x[i];
            rep.py   = p_y[i];
            rep.rot  = angle[i];
            rep.size = clamp32(longint'(size1[i]) +
                floor16((longint'(size0[i]) - longint'(size1[i])) * longint'(frac)));
            rep.frac = frac;
            rep.last = 1'b0;
            pending_reports.push_back(rep);
            n++;
        end
        if (n > 0)
            pending_reports[pending_reports.size() - 1].last = 1'b1;
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // drive one request in the current burst, returns the reports it queued
    task automatic send_req(input req_t r, output int n);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 7);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {1'b0, r.rs, r.rvy, r.rvx, r.ra, r.se, r.sb, r.dur,
                          r.vy, r.vx, r.py, r.px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        n = advance_pool(r);
    endtask

    // let the core drain before touching the spans
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_VEL_VAR_X: span_vx   = val;
            CFG_VEL_VAR_Y: span_vy   = val;
            CFG_SIZE_VAR:  span_size = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_spans(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
        write_cfg(CFG_UNUSED, $urandom);
        write_cfg(CFG_VEL_VAR_X, a);
        write_cfg(CFG_VEL_VAR_Y, b);
        write_cfg(CFG_SIZE_VAR, c);
    endtask

    function automatic req_t mk(input logic k, input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] vx, input logic [31:0] vy,
                                input logic [30:0] dur, input logic [31:0] sb,
                                input logic [31:0] se, input logic [15:0] ra,
                                input logic [15:0] rvx, input logic [15:0] rvy,
                                input logic [15:0] rs);
        req_t r;
        r.kind = k;  r.px = px;  r.py = py;  r.vx = vx;  r.vy = vy;  r.dur = dur;
        r.sb = sb;  r.se = se;  r.ra = ra;  r.rvx = rvx;  r.rvy = rvy;  r.rs = rs;
        return r;
    endfunction

    function automatic logic [31:0] wide32();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4, 5: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] frac16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short lifetimes and small steps so particles come and go
    function automatic req_t random_req();
        req_t r;
        r = mk(REQ_EMIT, wide32(), wide32(), wide32(), wide32(), '0, wide32(), wide32(),
               frac16(), frac16(), frac16(), frac16());
        if ($urandom_range(0, 9) < 3)
        begin
            r.kind = REQ_TICK;
            case ($urandom_range(0, 9))
                0: r.dur = '0;
                1: r.dur = 31'($urandom);
                default: r.dur = 31'($urandom_range(0, ONE));
            endcase
        end
        else if ($urandom_range(0, 9) == 0)
            r.dur = 31'($urandom);
        else
            r.dur = 31'($urandom_range(0, 6 * ONE));
        return r;
    endfunction

    // m_axis stall pattern: free running, coin flip, or mostly stalled
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // compare every result transaction with the oldest pending report
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected report", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[31:0] !== want.px)
                    report_mismatch("pos_x", m_axis_tdata[31:0], want.px);
                if (m_axis_tdata[63:32] !== want.py)
                    report_mismatch("pos_y", m_axis_tdata[63:32], want.py);
                if (m_axis_tdata[95:64] !== want.rot)
                    report_mismatch("rotation", m_axis_tdata[95:64], want.rot);
                if (m_axis_tdata[127:96] !== want.size)
                    report_mismatch("size", m_axis_tdata[127:96], want.size);
                if (m_axis_tdata[159:128] !== want.frac)
                    report_mismatch("life_fraction", m_axis_tdata[159:128], want.frac);
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    row_t directed[$];

    initial
    begin
        row_t row;
        int   n;
        report_t one;

        span_vx = 0;  span_vy = 0;  span_size = 0;
        ring_slot = POOL_SIZE - 1;
        for (int i = 0; i < POOL_SIZE; i++)
            alive[i] = 1'b0;

        // empty pool, zero lifetime, one plain particle over its whole life
        row.typed_n = 0;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.typed_n = -1;
        row.r = mk(REQ_EMIT, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.typed_n = 0;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.typed_n = -1;
        row.r = mk(REQ_EMIT, 7 * ONE, -3 * ONE, 0, 0, ONE, 2 * ONE, 2 * ONE,
                   0, 16'h8000, 16'h8000, 16'h8000);
        directed.push_back(row);
        row.typed_n = 1;
        one.px = 7 * ONE;  one.py = -3 * ONE;  one.rot = 0;  one.size = 2 * ONE;
        one.frac = ONE;  one.last = 1'b1;
        row.typed = one;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.typed_n = -1;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.typed_n = 0;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        // field extremes, with saturating motion and size
        row.typed_n = -1;
        row.r = mk(REQ_EMIT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   31'h7fffffff, 32'h7fffffff, 32'h80000000, 16'hffff, 16'hffff, 0, 16'hffff);
        directed.push_back(row);
        row.r = mk(REQ_EMIT, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   31'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 16'hffff, 0);
        directed.push_back(row);
        row.r = mk(REQ_EMIT, 0, 0, ONE, -ONE, 3 * ONE, 32'h80000000, 32'h7fffffff,
                   16'h8000, 16'h1234, 16'hfedc, 16'h0001);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 31'h7fffffff, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.r = mk(REQ_EMIT, -5, 5, -1, 1, 1, 1, -1, 1, 2, 3, 4);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 31'h7fffffff, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE / 2, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
        directed.push_back(row);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_spans(0, 0, 0);
        foreach (directed[i])
        begin
            send_req(directed[i].r, n);
            if (directed[i].typed_n >= 0)
            begin
                repeat (n) void'(pending_reports.pop_back());
                if (directed[i].typed_n == 1)
                    pending_reports.push_back(directed[i].typed);
            end
        end

        // random phases, spans at both extremes and in between
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_spans(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                1: set_spans(32'h80000000, 32'h80000000, 32'h80000000);
                2: set_spans($urandom, $urandom, $urandom);
                default: set_spans(0, ONE, -ONE);
            endcase
            repeat (90)
                send_req(random_req(), n);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
